### hw/rtl/sac_pkg.sv
// Package for the sequence alphabet classifier.
// Holds group indexes, result codes and the letter-to-group decode.
// No dependencies.
package sac_pkg;

  localparam int NGROUPS = 12;

  localparam int G_ALL    = 0;
  localparam int G_GAP    = 1;
  localparam int G_STAR   = 2;
  localparam int G_X      = 3;
  localparam int G_ATGCN  = 4;
  localparam int G_AUGCN  = 5;
  localparam int G_AUTGC  = 6;
  localparam int G_DNA2   = 7;
  localparam int G_RNA2   = 8;
  localparam int G_AMINO  = 9;
  localparam int G_NOTNUC = 10;
  localparam int G_DIGIT  = 11;

  typedef enum logic [2:0] {
    ALPHA_NUMERIC    = 3'd0,
    ALPHA_AMINO_STOP = 3'd1,
    ALPHA_AMINO      = 3'd2,
    ALPHA_DNA        = 3'd3,
    ALPHA_RNA        = 3'd4,
    ALPHA_NO_LETTERS = 3'd5,
    ALPHA_ONLY_GAPS  = 3'd6,
    ALPHA_UNKNOWN    = 3'd7
  } alpha_code_t;

  function automatic logic [NGROUPS-1:0] grp_hits(input logic [7:0] c);
    logic [NGROUPS-1:0] h;
    h           = '0;
    h[G_ALL]    = 1'b1;
    h[G_GAP]    = c inside {"-", "?", "="};
    h[G_STAR]   = (c == "*");
    h[G_X]      = (c == "X");
    h[G_ATGCN]  = c inside {"A", "T", "G", "C", "N"};
    h[G_AUGCN]  = c inside {"A", "U", "G", "C", "N"};
    h[G_AUTGC]  = c inside {"A", "U", "T", "G", "C"};
    h[G_DNA2]   = c inside {"A", "C", "G", "T", "N", "Y", "R", "W", "S", "K", "M"};
    h[G_RNA2]   = c inside {"A", "C", "G", "U", "N", "Y", "R", "W", "S", "K", "M"};
    h[G_AMINO]  = c inside {"A", "R", "N", "D", "C", "Q", "E", "G", "H", "I", "L",
                            "K", "M", "F", "P", "S", "T", "W", "Y", "V", "X"};
    h[G_NOTNUC] = c inside {"Q", "E", "I", "L", "F", "P", "J", "Z", "*"};
    h[G_DIGIT]  = c inside {["0":"9"]};
    return h;
  endfunction

endpackage

### hw/rtl/sequence_alphabet_classifier_core.sv
// Sequence alphabet classifier: counts letter groups per beat and classifies on last.
// Depends on sac_pkg.
// A last beat accepted on in_fire moves through s1_v, s2_v, s3_v, s4_v and out_valid.
// Throughput: one beat per cycle, last beats included, unless out_stall backs up the
// five-register decision pipeline (snapshot, denominators, products, compares, result).
// Reset: synchronous, clears all counters and every pipeline valid; no result pending.
module sequence_alphabet_classifier_core
  import sac_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] letter,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] alphabet_code
);

  localparam int CW = COUNT_WIDTH;
  localparam int PW = COUNT_WIDTH + 10;
  localparam logic [CW-1:0] CMAX = '1;

  logic [CW-1:0]      cnt      [NGROUPS];
  logic [CW-1:0]      cnt_next [NGROUPS];
  logic [CW-1:0]      snap     [NGROUPS];
  logic [NGROUPS-1:0] hits;
  logic               in_fire;

  logic s1_v, s2_v, s3_v, s4_v;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic          s2_empty, s2_gaps_only, s2_star_seen, s2_aug_le, s2_aug_ge;
  logic [CW-1:0] s2_den, s2_star, s2_xs;
  logic [CW-1:0] s2_dig, s2_aa, s2_notnuc, s2_autgc, s2_atgcn, s2_augcn, s2_dna2, s2_rna2;

  logic          s3_empty, s3_gaps_only, s3_star_seen, s3_aug_le, s3_aug_ge;
  logic [CW-1:0] s3_aaden, s3_digden;
  logic          s3_aaden_zero, s3_digden_zero;
  logic [PW-1:0] s3_p_dig, s3_p_aa, s3_p_notnuc, s3_p_autgc;
  logic [PW-1:0] s3_p_atgcn, s3_p_augcn, s3_p_dna2, s3_p_rna2;
  logic [PW-1:0] s3_d5, s3_d10, s3_d20, s3_d500, s3_d800, s3_d950;

  logic          s4_empty, s4_gaps_only, s4_star_seen, s4_aug_le, s4_aug_ge;
  logic          s4_aaden_zero, s4_digden_zero;
  logic [PW-1:0] s4_p_dig, s4_p_aa, s4_pa900, s4_pd950;
  logic          s4_nn5, s4_nn10, s4_nn20, s4_aut_b500, s4_aut_b800;
  logic          s4_atg_a950, s4_atg_a800, s4_aug_a950, s4_aug_a800;
  logic          s4_dna2_a950, s4_rna2_a950;

  logic          dig_ok, aa_ok, prot;
  alpha_code_t   code_next, code;

  assign hits    = grp_hits(letter);
  assign in_fire = in_valid && !in_stall;

  assign out_ready = !out_valid || !out_stall;
  assign s4_ready  = !s4_v || out_ready;
  assign s3_ready  = !s3_v || s4_ready;
  assign s2_ready  = !s2_v || s3_ready;
  assign s1_ready  = !s1_v || s2_ready;
  assign in_stall  = !s1_ready;

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      cnt_next[g] = (hits[g] && cnt[g] != CMAX) ? cnt[g] + 1'b1 : cnt[g];
    end
  end

  // advance counters; clear on last and hand the final counts to the snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NGROUPS; g++) cnt[g] <= '0;
    end else if (in_fire) begin
      for (int g = 0; g < NGROUPS; g++) cnt[g] <= last ? '0 : cnt_next[g];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      for (int g = 0; g < NGROUPS; g++) snap[g] <= cnt_next[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_v      <= in_fire && last;
      if (s2_ready)  s2_v      <= s1_v;
      if (s3_ready)  s3_v      <= s2_v;
      if (s4_ready)  s4_v      <= s3_v;
      if (out_ready) out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && s2_ready) begin
      s2_empty     <= (snap[G_ALL] == '0);
      s2_gaps_only <= (snap[G_ALL] <= snap[G_GAP]);
      s2_den       <= snap[G_ALL] - snap[G_GAP];
      s2_star      <= snap[G_STAR];
      s2_star_seen <= (snap[G_STAR] != '0);
      s2_xs        <= snap[G_X];
      s2_aug_le    <= (snap[G_AUGCN] <= snap[G_ATGCN]);
      s2_aug_ge    <= (snap[G_AUGCN] >= snap[G_ATGCN]);
      s2_dig       <= snap[G_DIGIT];
      s2_aa        <= snap[G_AMINO];
      s2_notnuc    <= snap[G_NOTNUC];
      s2_autgc     <= snap[G_AUTGC];
      s2_atgcn     <= snap[G_ATGCN];
      s2_augcn     <= snap[G_AUGCN];
      s2_dna2      <= snap[G_DNA2];
      s2_rna2      <= snap[G_RNA2];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && s3_ready) begin
      s3_empty       <= s2_empty;
      s3_gaps_only   <= s2_gaps_only;
      s3_star_seen   <= s2_star_seen;
      s3_aug_le      <= s2_aug_le;
      s3_aug_ge      <= s2_aug_ge;
      s3_aaden       <= (s2_den > s2_star) ? s2_den - s2_star : '0;
      s3_aaden_zero  <= (s2_den <= s2_star);
      s3_digden      <= (s2_den > s2_xs) ? s2_den - s2_xs : '0;
      s3_digden_zero <= (s2_den <= s2_xs);
      s3_p_dig       <= PW'(s2_dig) * PW'(1000);
      s3_p_aa        <= PW'(s2_aa) * PW'(1000);
      s3_p_notnuc    <= PW'(s2_notnuc) * PW'(1000);
      s3_p_autgc     <= PW'(s2_autgc) * PW'(1000);
      s3_p_atgcn     <= PW'(s2_atgcn) * PW'(1000);
      s3_p_augcn     <= PW'(s2_augcn) * PW'(1000);
      s3_p_dna2      <= PW'(s2_dna2) * PW'(1000);
      s3_p_rna2      <= PW'(s2_rna2) * PW'(1000);
      s3_d5          <= PW'(s2_den) * PW'(5);
      s3_d10         <= PW'(s2_den) * PW'(10);
      s3_d20         <= PW'(s2_den) * PW'(20);
      s3_d500        <= PW'(s2_den) * PW'(500);
      s3_d800        <= PW'(s2_den) * PW'(800);
      s3_d950        <= PW'(s2_den) * PW'(950);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v && s4_ready) begin
      s4_empty       <= s3_empty;
      s4_gaps_only   <= s3_gaps_only;
      s4_star_seen   <= s3_star_seen;
      s4_aug_le      <= s3_aug_le;
      s4_aug_ge      <= s3_aug_ge;
      s4_aaden_zero  <= s3_aaden_zero;
      s4_digden_zero <= s3_digden_zero;
      s4_p_dig       <= s3_p_dig;
      s4_p_aa        <= s3_p_aa;
      s4_pa900       <= PW'(s3_aaden) * PW'(900);
      s4_pd950       <= PW'(s3_digden) * PW'(950);
      s4_nn5         <= s3_p_notnuc > s3_d5;
      s4_nn10        <= s3_p_notnuc > s3_d10;
      s4_nn20        <= s3_p_notnuc > s3_d20;
      s4_aut_b500    <= s3_p_autgc < s3_d500;
      s4_aut_b800    <= s3_p_autgc < s3_d800;
      s4_atg_a950    <= s3_p_atgcn > s3_d950;
      s4_atg_a800    <= s3_p_atgcn > s3_d800;
      s4_aug_a950    <= s3_p_augcn > s3_d950;
      s4_aug_a800    <= s3_p_augcn > s3_d800;
      s4_dna2_a950   <= s3_p_dna2 > s3_d950;
      s4_rna2_a950   <= s3_p_rna2 > s3_d950;
    end
  end

  assign dig_ok = !s4_digden_zero && (s4_p_dig > s4_pd950);
  assign aa_ok  = !s4_aaden_zero && (s4_p_aa > s4_pa900);
  assign prot   = aa_ok && s4_nn5 && (s4_aut_b500 || s4_nn10) && (s4_aut_b800 || s4_nn20);

  always_comb begin
    if (s4_empty) begin
      code_next = ALPHA_NO_LETTERS;
    end else if (s4_gaps_only) begin
      code_next = ALPHA_ONLY_GAPS;
    end else if (dig_ok) begin
      code_next = ALPHA_NUMERIC;
    end else if (prot) begin
      code_next = s4_star_seen ? ALPHA_AMINO_STOP : ALPHA_AMINO;
    end else if (s4_atg_a950 && s4_aug_le) begin
      code_next = ALPHA_DNA;
    end else if (s4_aug_a950 && s4_aug_ge) begin
      code_next = ALPHA_RNA;
    end else if (s4_atg_a800 && s4_dna2_a950 && !s4_aug_ge) begin
      code_next = ALPHA_DNA;
    end else if (s4_aug_a800 && s4_rna2_a950 && !s4_aug_le) begin
      code_next = ALPHA_RNA;
    end else begin
      code_next = ALPHA_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v && out_ready) code <= code_next;
  end

  assign alphabet_code = code;

endmodule

### hw/rtl/sac_checker.sv
// Port-level checks for the sequence alphabet classifier.
// Bound to sequence_alphabet_classifier_core; no package dependency.
module sac_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] alphabet_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(alphabet_code))
    else $error("result beat changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind sequence_alphabet_classifier_core sac_port_checker u_sac_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .alphabet_code (alphabet_code)
);
